// ===== design/normalized_forgetting_average_top_assert.svh =====
// Assertion macros for the normalized forgetting average block.
// Used by normalized_forgetting_average_top; no other dependencies.
`ifndef NORMALIZED_FORGETTING_AVERAGE_TOP_ASSERT_SVH
`define NORMALIZED_FORGETTING_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nfa_pkg.sv =====
// Shared types and constants for the normalized forgetting average block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nfa_pkg;

    // Field and state widths
    localparam int FF_W   = 16;   // forget factor, Q0.16
    localparam int WS_W   = 33;   // weight sum, Q17.16
    localparam int DATA_W = 16;   // sample and average
    localparam int DIFF_W = 17;   // sample minus average
    localparam int MAG_W  = 16;   // magnitude of the difference
    localparam int QUOT_W = 16;   // quotient bits, weight sum is at least 1.0

    localparam logic [WS_W-1:0] WS_ONE   = 33'h0_0001_0000;
    localparam logic [WS_W-1:0] WS_MAX   = {WS_W{1'b1}};
    localparam logic [FF_W-1:0] FF_RESET = 16'd58982;

    // Item operation codes
    typedef enum logic {
        OP_FILTER  = 1'b0,
        OP_REFRESH = 1'b1
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== design/nfa_mul.sv =====
// Bit-serial weight update: floor(ff * ws / 2^16) + 1.0, saturated.
// Depends on nfa_pkg.
`timescale 1ns / 1ps

module nfa_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [nfa_pkg::FF_W-1:0] i_ff,
    input  logic [nfa_pkg::WS_W-1:0] i_ws,
    output logic                     o_done,
    output logic [nfa_pkg::WS_W-1:0] o_ws_next
);
    import nfa_pkg::*;

    localparam int CNT_W = $clog2(FF_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [FF_W-1:0]  r_ff;
    logic [WS_W-1:0]  r_ws;
    logic [WS_W-1:0]  r_acc;
    logic [WS_W:0]    n_sum;
    logic [WS_W:0]    w_add_one;

    // One multiplier bit per cycle, LSB first; shifted-out bits are the dropped fraction
    assign n_sum = {1'b0, r_acc} + (r_ff[0] ? {1'b0, r_ws} : '0);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator stays below the multiplicand
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_ff  <= i_ff;
            r_ws  <= i_ws;
        end else if (r_busy) begin
            r_acc <= n_sum[WS_W:1];
            r_ff  <= r_ff >> 1;
        end
    end

    // Add 1.0 and saturate
    assign w_add_one = {1'b0, r_acc} + {1'b0, WS_ONE};
    assign o_ws_next = w_add_one[WS_W] ? WS_MAX : w_add_one[WS_W-1:0];
    assign o_done    = r_done;

endmodule

// ===== design/nfa_div.sv =====
// Restoring divider, one quotient bit per cycle: (mag * 2^16) / divisor.
// Depends on nfa_pkg; the divisor must exceed mag (weight sum is at least 1.0).
`timescale 1ns / 1ps

module nfa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nfa_pkg::MAG_W-1:0]  i_mag,
    input  logic [nfa_pkg::WS_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [nfa_pkg::QUOT_W-1:0] o_quot
);
    import nfa_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WS_W-1:0]   r_rem;
    logic [WS_W-1:0]   r_divisor;
    logic [QUOT_W-1:0] r_quot;
    logic [WS_W:0]     w_trial;
    logic [WS_W:0]     w_diff;
    logic              w_fits;

    // Shift in a zero dividend bit and try a subtract
    assign w_trial = {r_rem, 1'b0};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: upper dividend bits preload the remainder, quotient shifts in LSB
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= {{(WS_W-MAG_W){1'b0}}, i_mag};
            r_divisor <= i_divisor;
            r_quot    <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fits ? w_diff[WS_W-1:0] : w_trial[WS_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/normalized_forgetting_average_top.sv =====
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_op, i_sample
// result    o_out_valid   i_out_stall   o_average
// config    i_cfg_wr_en   -             i_cfg_wr_data (forget factor)
//
// A filter item runs the bit-serial weight multiply, then the bit-serial
// divide, then the output step; a refresh item goes straight to the output
// step. One item is in flight at a time.
// The result sits in an output register; a stalled result holds the block
// only once the next result is ready to be written.
// Reset (i_rst_n low, synchronous) sets weight sum to 1.0, average to 0.
`timescale 1ns / 1ps
`include "normalized_forgetting_average_top_assert.svh"

module normalized_forgetting_average_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [nfa_pkg::FF_W-1:0]          i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic signed [nfa_pkg::DATA_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [nfa_pkg::DATA_W-1:0] o_average
);
    import nfa_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [FF_W-1:0]          r_ff;
    logic [WS_W-1:0]          r_ws;
    logic signed [DATA_W-1:0] r_avg;
    logic signed [DATA_W-1:0] r_sample;
    logic                     r_neg;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_avg;

    logic                     w_in_acc;
    logic                     w_refresh;
    logic                     w_mul_start;
    logic                     w_div_start;
    logic                     w_avg_load;
    logic                     w_out_load;
    logic                     w_mul_done;
    logic [WS_W-1:0]          w_ws_next;
    logic                     w_div_done;
    logic [QUOT_W-1:0]        w_quot;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_diff_neg;
    logic [MAG_W-1:0]         w_mag;
    logic signed [DIFF_W:0]   w_avg_wide;
    logic signed [DIFF_W:0]   w_quot_wide;
    logic signed [DIFF_W:0]   w_avg_sum;
    logic signed [DATA_W-1:0] w_avg_clamped;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_refresh = (i_op == OP_REFRESH);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff <= FF_RESET;
        end else if (i_cfg_wr_en) begin
            r_ff <= i_cfg_wr_data;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_avg_load  = 1'b0;
        w_out_load  = 1'b0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (w_refresh) begin
                        n_state = ST_OUT;
                    end else begin
                        w_mul_start = 1'b1;
                        n_state     = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_avg_load = 1'b1;
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Filter state: weight sum and average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws  <= WS_ONE;
            r_avg <= '0;
        end else if (w_in_acc && w_refresh) begin
            r_ws  <= WS_ONE;
            r_avg <= '0;
        end else begin
            if (w_div_start) begin
                r_ws <= w_ws_next;
            end
            if (w_avg_load) begin
                r_avg <= w_avg_clamped;
            end
        end
    end

    // Item payload and sign of the difference
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_sample;
        end
        if (w_div_start) begin
            r_neg <= w_diff[DIFF_W-1];
        end
    end

    // Difference magnitude; fits 16 bits since |diff| <= 65535
    assign w_diff     = DIFF_W'(r_sample) - DIFF_W'(r_avg);
    assign w_diff_neg = -w_diff;
    assign w_mag      = w_diff[DIFF_W-1] ? w_diff_neg[MAG_W-1:0] : w_diff[MAG_W-1:0];

    // Average step with a range clamp
    assign w_avg_wide  = (DIFF_W+1)'(r_avg);
    assign w_quot_wide = $signed({{(DIFF_W+1-QUOT_W){1'b0}}, w_quot});
    assign w_avg_sum   = r_neg ? (w_avg_wide - w_quot_wide) : (w_avg_wide + w_quot_wide);

    always_comb begin
        priority if (w_avg_sum > (DIFF_W+1)'(32767)) begin
            w_avg_clamped = DATA_W'(32767);
        end else if (w_avg_sum < -(DIFF_W+1)'(32768)) begin
            w_avg_clamped = DATA_W'(-32768);
        end else begin
            w_avg_clamped = w_avg_sum[DATA_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_avg <= r_avg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_average   = r_out_avg;

    // Weight update unit
    nfa_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_ff      (r_ff),
        .i_ws      (r_ws),
        .o_done    (w_mul_done),
        .o_ws_next (w_ws_next)
    );

    // Step divider, divisor is the freshly updated weight sum
    nfa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_mag     (w_mag),
        .i_divisor (w_ws_next),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Checks
    `NFA_ASSERT_NOW(a_ws_floor, i_clk, i_rst_n, 1'b1, r_ws >= WS_ONE, "weight sum below 1.0")
    `NFA_ASSERT_NOW(a_mul_done_state, i_clk, i_rst_n, w_mul_done, r_state == ST_MUL, "stray multiply done")
    `NFA_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "stray divide done")
    `NFA_ASSERT_NEXT(a_refresh, i_clk, i_rst_n, w_in_acc && w_refresh, (r_ws == WS_ONE) && (r_avg == 0), "refresh did not clear state")

endmodule
